// ===== src/wis_pkg.sv =====
// Shared types, sizes and codes for the weighted index sampler.
package wis_pkg;

    localparam int unsigned MAX_ITEMS   = 1024;
    localparam int unsigned WEIGHT_BITS = 16;
    localparam int unsigned COUNT_BITS  = 32;

    localparam int unsigned ADDR_W  = $clog2(MAX_ITEMS);
    localparam int unsigned LOAD_W  = $clog2(MAX_ITEMS + 1);
    localparam int unsigned TOTAL_W = 26;
    localparam int unsigned ALU_W   = (COUNT_BITS > TOTAL_W + 1) ? COUNT_BITS : TOTAL_W + 1;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [15:0] WEIGHT_MASK =
        (WEIGHT_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << WEIGHT_BITS) - 32'd1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] weight;
        logic [25:0] rand_value;
        logic [10:0] query_index;
    } t_in;

    typedef struct packed {
        logic [10:0] item_index;
        logic [31:0] hit_count;
        logic [25:0] total_weight;
        logic [1:0]  error_code;
    } t_out;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_LOAD  = 2'd0;
    localparam t_kind KIND_DRAW  = 2'd1;
    localparam t_kind KIND_READ  = 2'd2;
    localparam t_kind KIND_CLEAR = 2'd3;

    typedef logic [1:0] t_err;
    localparam t_err ERR_OK        = 2'd0;
    localparam t_err ERR_NOT_BELOW = 2'd1;
    localparam t_err ERR_FULL      = 2'd2;
    localparam t_err ERR_BAD_INDEX = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ITEM_COUNT = 2'd0;
    localparam t_cfg_idx CFG_RECORD     = 2'd1;

    typedef logic [1:0] t_alu_op;
    localparam t_alu_op ALU_GT      = 2'd0;
    localparam t_alu_op ALU_ADD_SAT = 2'd1;
    localparam t_alu_op ALU_INC_SAT = 2'd2;

endpackage

// ===== src/wis_ram.sv =====
// Single-port RAM with registered read data.
module wis_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/wis_alu.sv =====
// Shared compare / saturating add / saturating increment unit.
module wis_alu (
    input  wis_pkg::t_alu_op           i_op,
    input  logic [wis_pkg::ALU_W-1:0]  i_a,
    input  logic [wis_pkg::ALU_W-1:0]  i_b,
    output logic [wis_pkg::ALU_W-1:0]  o_res,
    output logic                       o_flag
);

    logic [wis_pkg::ALU_W:0]         w_sum;
    logic [wis_pkg::COUNT_BITS-1:0]  w_cnt;

    assign w_sum = {1'b0, i_a} + {1'b0, i_b};
    assign w_cnt = i_a[wis_pkg::COUNT_BITS-1:0];

    always_comb begin
        o_res  = i_a;
        o_flag = 1'b0;
        case (i_op)
            wis_pkg::ALU_GT: begin
                o_flag = (i_a > i_b);
            end
            wis_pkg::ALU_ADD_SAT: begin
                if (w_sum > (wis_pkg::ALU_W + 1)'(wis_pkg::TOTAL_MAX)) begin
                    o_res  = wis_pkg::ALU_W'(wis_pkg::TOTAL_MAX);
                    o_flag = 1'b1;
                end else begin
                    o_res = w_sum[wis_pkg::ALU_W-1:0];
                end
            end
            wis_pkg::ALU_INC_SAT: begin
                if (w_cnt == '1) begin
                    o_res  = wis_pkg::ALU_W'(w_cnt);
                    o_flag = 1'b1;
                end else begin
                    o_res = wis_pkg::ALU_W'(w_cnt) + wis_pkg::ALU_W'(1);
                end
            end
            default: begin
                o_res  = i_a;
                o_flag = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/weighted_index_sampler.sv =====
// Top level: sequencer, level and hit-count memories, shared ALU.
//
//  channel | direction | handshake                   | payload
//  in      | input     | i_in_valid / o_in_ready     | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_ready   | o_out_data (t_out)
//  cfg     | input     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// From accept to result valid: load, clear and rejected transactions pass dispatch and
// output; read adds hit address and hit; draw adds a binary search, each probe one
// level memory read and one ALU compare. o_in_ready rises as the result is registered.
// One transaction at a time; o_in_ready is high only while the sequencer idles.
// A stalled result waits in the output register; the next transaction is
// accepted meanwhile. Reset is synchronous; no memory clearing pass is needed.
module weighted_index_sampler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  wis_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output wis_pkg::t_out                      o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wis_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wis_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_HADDR = 3'd4;
    localparam logic [2:0] S_HIT   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                    r_state, n_state;
    wis_pkg::t_in                  r_in, n_in;
    logic [wis_pkg::ADDR_W-1:0]    r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [wis_pkg::LOAD_W-1:0]    r_loaded, n_loaded;
    logic [wis_pkg::TOTAL_W-1:0]   r_total, n_total;
    logic [10:0]                   r_item_count;
    logic                          r_record;
    wis_pkg::t_out                 r_res, n_res;
    wis_pkg::t_out                 r_out;
    logic                          r_out_valid;

    logic                          w_in_acc;
    logic                          w_out_free;
    logic                          w_full;
    logic [wis_pkg::COUNT_BITS-1:0] w_new_hit;

    logic                          cum_we;
    logic [wis_pkg::ADDR_W-1:0]    cum_addr;
    logic [wis_pkg::TOTAL_W-1:0]   cum_wdata, cum_rdata;
    logic                          hit_we;
    logic [wis_pkg::ADDR_W-1:0]    hit_addr;
    logic [wis_pkg::COUNT_BITS-1:0] hit_wdata, hit_rdata;

    wis_pkg::t_alu_op              alu_op;
    logic [wis_pkg::ALU_W-1:0]     alu_a, alu_b, alu_res;
    logic                          alu_flag;

    function automatic wis_pkg::t_out f_err(input wis_pkg::t_err code,
                                            input logic [wis_pkg::TOTAL_W-1:0] total);
        wis_pkg::t_out res;
        res.item_index   = '0;
        res.hit_count    = '0;
        res.total_weight = total;
        res.error_code   = code;
        return res;
    endfunction

    wis_ram #(.DEPTH(wis_pkg::MAX_ITEMS), .WIDTH(wis_pkg::TOTAL_W)) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (cum_we),
        .i_addr  (cum_addr),
        .i_wdata (cum_wdata),
        .o_rdata (cum_rdata)
    );

    wis_ram #(.DEPTH(wis_pkg::MAX_ITEMS), .WIDTH(wis_pkg::COUNT_BITS)) u_hit_ram (
        .i_clk   (i_clk),
        .i_we    (hit_we),
        .i_addr  (hit_addr),
        .i_wdata (hit_wdata),
        .o_rdata (hit_rdata)
    );

    wis_alu u_alu (
        .i_op   (alu_op),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_res  (alu_res),
        .o_flag (alu_flag)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_full = (32'(r_loaded) >= 32'(r_item_count)) ||
                    (32'(r_loaded) >= 32'(wis_pkg::MAX_ITEMS));

    // hit entries at or above the fill count are never read, so a freshly
    // loaded slot is written with zero instead of clearing the whole memory
    assign w_new_hit = r_record ? alu_res[wis_pkg::COUNT_BITS-1:0] : hit_rdata;

    always_comb begin
        n_state   = r_state;
        n_in      = r_in;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_loaded  = r_loaded;
        n_total   = r_total;
        n_res     = r_res;
        cum_we    = 1'b0;
        cum_addr  = r_mid;
        cum_wdata = alu_res[wis_pkg::TOTAL_W-1:0];
        hit_we    = 1'b0;
        hit_addr  = r_lo;
        hit_wdata = w_new_hit;
        alu_op    = wis_pkg::ALU_GT;
        alu_a     = '0;
        alu_b     = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_in    = i_in_data;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_in.kind)
                    wis_pkg::KIND_LOAD: begin
                        alu_op = wis_pkg::ALU_ADD_SAT;
                        alu_a  = wis_pkg::ALU_W'(r_total);
                        alu_b  = wis_pkg::ALU_W'(r_in.weight & wis_pkg::WEIGHT_MASK);
                        if (w_full) begin
                            n_res = f_err(wis_pkg::ERR_FULL, r_total);
                        end else begin
                            n_total   = alu_res[wis_pkg::TOTAL_W-1:0];
                            cum_we    = 1'b1;
                            cum_addr  = r_loaded[wis_pkg::ADDR_W-1:0];
                            hit_we    = 1'b1;
                            hit_addr  = r_loaded[wis_pkg::ADDR_W-1:0];
                            hit_wdata = '0;
                            n_loaded  = r_loaded + wis_pkg::LOAD_W'(1);
                            n_res.item_index   = 11'(r_loaded + wis_pkg::LOAD_W'(1));
                            n_res.hit_count    = '0;
                            n_res.total_weight = alu_res[wis_pkg::TOTAL_W-1:0];
                            n_res.error_code   = wis_pkg::ERR_OK;
                        end
                        n_state = S_OUT;
                    end
                    wis_pkg::KIND_DRAW: begin
                        alu_op = wis_pkg::ALU_GT;
                        alu_a  = wis_pkg::ALU_W'(r_total);
                        alu_b  = wis_pkg::ALU_W'(r_in.rand_value);
                        if (!alu_flag) begin
                            n_res   = f_err(wis_pkg::ERR_NOT_BELOW, r_total);
                            n_state = S_OUT;
                        end else begin
                            // total above rand implies at least one loaded item
                            n_lo    = '0;
                            n_hi    = wis_pkg::ADDR_W'(r_loaded - wis_pkg::LOAD_W'(1));
                            n_state = S_RD;
                        end
                    end
                    wis_pkg::KIND_READ: begin
                        if (r_in.query_index == '0 ||
                            32'(r_in.query_index) > 32'(r_loaded)) begin
                            n_res   = f_err(wis_pkg::ERR_BAD_INDEX, r_total);
                            n_state = S_OUT;
                        end else begin
                            n_lo    = wis_pkg::ADDR_W'(r_in.query_index - 11'd1);
                            n_state = S_HADDR;
                        end
                    end
                    default: begin
                        n_loaded = '0;
                        n_total  = '0;
                        n_res    = f_err(wis_pkg::ERR_OK, '0);
                        n_state  = S_OUT;
                    end
                endcase
            end
            S_RD: begin
                if (r_lo < r_hi) begin
                    n_mid    = r_lo + ((r_hi - r_lo) >> 1);
                    cum_addr = n_mid;
                    n_state  = S_CMP;
                end else begin
                    n_state = S_HADDR;
                end
            end
            S_CMP: begin
                alu_op = wis_pkg::ALU_GT;
                alu_a  = wis_pkg::ALU_W'(cum_rdata);
                alu_b  = wis_pkg::ALU_W'(r_in.rand_value);
                if (alu_flag) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + wis_pkg::ADDR_W'(1);
                end
                n_state = S_RD;
            end
            S_HADDR: begin
                n_state = S_HIT;
            end
            S_HIT: begin
                alu_op = wis_pkg::ALU_INC_SAT;
                alu_a  = wis_pkg::ALU_W'(hit_rdata);
                n_res.total_weight = r_total;
                n_res.error_code   = wis_pkg::ERR_OK;
                if (r_in.kind == wis_pkg::KIND_DRAW) begin
                    hit_we           = r_record;
                    n_res.item_index = 11'(wis_pkg::LOAD_W'(r_lo) + wis_pkg::LOAD_W'(1));
                    n_res.hit_count  = 32'(w_new_hit);
                end else begin
                    n_res.item_index = r_in.query_index;
                    n_res.hit_count  = 32'(hit_rdata);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_loaded     <= '0;
            r_total      <= '0;
            r_item_count <= 11'(wis_pkg::MAX_ITEMS);
            r_record     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
            r_total  <= n_total;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == wis_pkg::CFG_ITEM_COUNT) begin
                    r_item_count <= i_cfg_data[10:0];
                end else if (i_cfg_index == wis_pkg::CFG_RECORD) begin
                    r_record <= i_cfg_data[0];
                end
            end
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_res <= n_res;
        if (r_state == S_OUT && w_out_free) begin
            r_out <= r_res;
        end
    end

    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_loaded) <= 32'(wis_pkg::MAX_ITEMS))
        else $error("fill count beyond table depth");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_lo <= r_hi) && (32'(r_hi) < 32'(r_loaded)))
        else $error("search window left the loaded range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error_code != wis_pkg::ERR_OK) |->
        (r_out.item_index == '0) && (r_out.hit_count == '0))
        else $error("error result carries an index or count");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_DISP))
        else $error("accepted transaction not dispatched");

endmodule
